[rtl/khrt_pkg.sv]
// Package for the key hold and repeat tracker.
// Holds the sizing constants, register indexes and the structs shared by the lanes,
// the merge stage and the top level. It depends on nothing else.
package khrt_pkg;

    // Number of action lanes and the width of each lane's hold counter.
    localparam int NUM_ACTIONS = 10;
    localparam int COUNT_WIDTH = 16;

    // The input and output vectors carry a fixed ten actions.
    localparam int VEC_W = 10;
    // Only lanes that can see a press are built.
    localparam int LIVE_LANES = (NUM_ACTIONS < VEC_W) ? NUM_ACTIONS : VEC_W;

    // Configuration field widths.
    localparam int CFG_W       = 16;
    localparam int LOCK_W      = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int PHASE_W     = 16;
    // Common width for comparing a hold count against a 16-bit setting.
    localparam int CMP_W = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_THRESHOLD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_WAIT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_INTERVAL = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOCKOUT_LENGTH  = 2'd3;

    // Settings that every lane uses, with zero already mapped to one.
    typedef struct packed {
        logic [CFG_W-1:0] threshold;
        logic [CFG_W-1:0] rpt_wait;
        logic [CFG_W-1:0] interval;
    } t_lane_cfg;

    // What one lane found for the current word.
    typedef struct packed {
        logic held;
        logic press_edge;
        logic release_edge;
        logic long_hold;
        logic repeat_pulse;
    } t_lane_flags;

    // One result word.
    typedef struct packed {
        logic [VEC_W-1:0] held_bits;
        logic [VEC_W-1:0] press_edge_bits;
        logic [VEC_W-1:0] release_edge_bits;
        logic [VEC_W-1:0] long_hold_bits;
        logic [VEC_W-1:0] repeat_bits;
        logic             locked_out;
    } t_result;

endpackage

[rtl/khrt_channels.sv]
// Channel interfaces of the key hold and repeat tracker: input words, result words
// and configuration writes. Each has a source and a sink modport.
// Depends on khrt_pkg for the field widths.
interface khrt_in_if;
    logic                             valid;
    logic                             ready;
    logic [khrt_pkg::VEC_W-1:0]       pressed_bits;
    logic                             lockout_request;

    modport source (output valid, output pressed_bits, output lockout_request, input ready);
    modport sink   (input valid, input pressed_bits, input lockout_request, output ready);
endinterface

interface khrt_out_if;
    logic                             valid;
    logic                             ready;
    logic [khrt_pkg::VEC_W-1:0]       held_bits;
    logic [khrt_pkg::VEC_W-1:0]       press_edge_bits;
    logic [khrt_pkg::VEC_W-1:0]       release_edge_bits;
    logic [khrt_pkg::VEC_W-1:0]       long_hold_bits;
    logic [khrt_pkg::VEC_W-1:0]       repeat_bits;
    logic                             locked_out;

    modport source (output valid, output held_bits, output press_edge_bits,
                    output release_edge_bits, output long_hold_bits, output repeat_bits,
                    output locked_out, input ready);
    modport sink   (input valid, input held_bits, input press_edge_bits,
                    input release_edge_bits, input long_hold_bits, input repeat_bits,
                    input locked_out, output ready);
endinterface

interface khrt_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [khrt_pkg::CFG_IDX_W-1:0]   index;
    logic [khrt_pkg::CFG_W-1:0]       data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/key_hold_repeat_tracker.sv]
// Key hold and repeat tracker, top level.
// Takes one word per frame on the input channel: a pressed bit for each of ten
// actions and a lockout request. Returns one result word per input word on the
// output channel: held, press edge, release edge, long hold and typematic repeat
// vectors, plus a locked-out flag that forces the five vectors to zero.
// Each action has its own lane (hold counter, repeat phase); a merge stage applies
// the lockout counter and registers the result.
// The result of an accepted word is registered and shown on the output in the following cycle.
// Throughput is one word per cycle, set by the single output register: the input
// is ready whenever that register is empty or being taken in the same cycle.
// When the receiver stalls, the result word is held and input ready stays low
// until it is taken, so nothing is stored beyond the output register.
// The configuration channel is always ready; write it only while the block is idle.
// Reset (synchronous, active low) clears all lane counters and the lockout counter
// and loads threshold 30, wait 30, interval 5 and lockout length 10.
// Depends on khrt_pkg, khrt_channels, khrt_lane and khrt_merge.
module key_hold_repeat_tracker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    khrt_in_if.sink    i_in_ch,
    khrt_out_if.source o_out_ch,
    khrt_cfg_if.sink   i_cfg_ch
);
    import khrt_pkg::*;

    logic [CFG_W-1:0]  r_threshold;
    logic [CFG_W-1:0]  r_rpt_wait;
    logic [CFG_W-1:0]  r_interval;
    logic [LOCK_W-1:0] r_lock_len;
    t_lane_cfg         lane_cfg;
    t_lane_flags       lane_flags [LIVE_LANES];
    t_result           result;
    logic              in_ready;
    logic              in_accept;

    // Configuration registers.
    assign i_cfg_ch.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= CFG_W'(30);
            r_rpt_wait  <= CFG_W'(30);
            r_interval  <= CFG_W'(5);
            r_lock_len  <= LOCK_W'(10);
        end else if (i_cfg_ch.valid) begin
            case (i_cfg_ch.index)
                REG_HOLD_THRESHOLD:  r_threshold <= i_cfg_ch.data;
                REG_REPEAT_WAIT:     r_rpt_wait  <= i_cfg_ch.data;
                REG_REPEAT_INTERVAL: r_interval  <= i_cfg_ch.data;
                REG_LOCKOUT_LENGTH:  r_lock_len  <= i_cfg_ch.data[LOCK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Settings of zero behave as one.
    always_comb begin
        lane_cfg.threshold = (r_threshold == '0) ? CFG_W'(1) : r_threshold;
        lane_cfg.rpt_wait  = (r_rpt_wait == '0)  ? CFG_W'(1) : r_rpt_wait;
        lane_cfg.interval  = (r_interval == '0)  ? CFG_W'(1) : r_interval;
    end

    assign in_accept     = i_in_ch.valid && in_ready;
    assign i_in_ch.ready = in_ready;

    // One lane per action.
    for (genvar g = 0; g < LIVE_LANES; g++) begin : g_lane
        khrt_lane u_lane (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_accept  (in_accept),
            .i_pressed (i_in_ch.pressed_bits[g]),
            .i_cfg     (lane_cfg),
            .o_flags   (lane_flags[g])
        );
    end

    // Lockout, masking and output register.
    khrt_merge u_merge (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_accept          (in_accept),
        .i_lockout_request (i_in_ch.lockout_request),
        .i_lockout_length  (r_lock_len),
        .i_flags           (lane_flags),
        .i_out_ready       (o_out_ch.ready),
        .o_in_ready        (in_ready),
        .o_out_valid       (o_out_ch.valid),
        .o_result          (result)
    );

    assign o_out_ch.held_bits         = result.held_bits;
    assign o_out_ch.press_edge_bits   = result.press_edge_bits;
    assign o_out_ch.release_edge_bits = result.release_edge_bits;
    assign o_out_ch.long_hold_bits    = result.long_hold_bits;
    assign o_out_ch.repeat_bits       = result.repeat_bits;
    assign o_out_ch.locked_out        = result.locked_out;

endmodule

[rtl/khrt_lane.sv]
// One action lane: saturating hold counter and typematic repeat phase.
// Flags for the current word are combinational; state advances on an accepted word.
// Depends on khrt_pkg.
module khrt_lane (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_accept,
    input  logic                    i_pressed,
    input  khrt_pkg::t_lane_cfg     i_cfg,
    output khrt_pkg::t_lane_flags   o_flags
);
    import khrt_pkg::*;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    logic [COUNT_WIDTH-1:0] r_hold;
    logic [COUNT_WIDTH-1:0] n_hold;
    logic [PHASE_W-1:0]     r_phase;
    logic [PHASE_W-1:0]     n_phase;
    logic [PHASE_W:0]       phase_inc;
    logic [CMP_W-1:0]       old_x;
    logic [CMP_W-1:0]       now_x;
    logic [CMP_W-1:0]       wait_x;
    logic [CMP_W-1:0]       thr_x;
    logic                   in_repeat;
    logic                   first_frame;

    // Next hold count: count up while pressed, stop at the top, clear on release.
    always_comb begin
        if (!i_pressed) begin
            n_hold = '0;
        end else if (r_hold == COUNT_MAX) begin
            n_hold = r_hold;
        end else begin
            n_hold = r_hold + 1'b1;
        end
    end

    assign old_x  = CMP_W'(r_hold);
    assign now_x  = CMP_W'(n_hold);
    assign wait_x = CMP_W'(i_cfg.rpt_wait);
    assign thr_x  = CMP_W'(i_cfg.threshold);

    assign in_repeat   = (now_x >= wait_x);
    assign first_frame = (n_hold == COUNT_WIDTH'(1));
    assign phase_inc   = {1'b0, r_phase} + 1'b1;

    // Repeat phase restarts on reaching the wait count and wraps every interval frames.
    always_comb begin
        if (!in_repeat || (old_x < wait_x)) begin
            n_phase = '0;
        end else if (phase_inc >= {1'b0, i_cfg.interval}) begin
            n_phase = '0;
        end else begin
            n_phase = phase_inc[PHASE_W-1:0];
        end
    end

    // Flags for this word.
    always_comb begin
        o_flags.held         = (n_hold != '0);
        o_flags.press_edge   = (n_hold != '0) && (r_hold == '0);
        o_flags.release_edge = (n_hold == '0) && (r_hold != '0);
        o_flags.long_hold    = (now_x >= thr_x);
        o_flags.repeat_pulse = first_frame || (in_repeat && (n_phase == '0));
    end

    // Lane state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold  <= '0;
            r_phase <= '0;
        end else if (i_accept) begin
            r_hold  <= n_hold;
            r_phase <= n_phase;
        end
    end

endmodule

[rtl/khrt_merge.sv]
// Merge stage: gathers the lane flags into result vectors, applies the lockout
// mask and holds the result word in an output register. Depends on khrt_pkg.
module khrt_merge (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic                        i_lockout_request,
    input  logic [khrt_pkg::LOCK_W-1:0] i_lockout_length,
    input  khrt_pkg::t_lane_flags       i_flags [khrt_pkg::LIVE_LANES],
    input  logic                        i_out_ready,
    output logic                        o_in_ready,
    output logic                        o_out_valid,
    output khrt_pkg::t_result           o_result
);
    import khrt_pkg::*;

    logic [LOCK_W-1:0] r_lock_count;
    logic [LOCK_W-1:0] n_lock_count;
    logic [LOCK_W-1:0] lock_start;
    logic              locked;
    logic              r_valid;
    t_result           r_result;
    t_result           n_result;

    // The output register takes a new word whenever it is empty or being drained.
    assign o_in_ready = !r_valid || i_out_ready;

    // Lockout: a request reloads the counter, then any nonzero count masks this word.
    always_comb begin
        lock_start   = i_lockout_request ? i_lockout_length : r_lock_count;
        locked       = (lock_start != '0);
        n_lock_count = locked ? lock_start - 1'b1 : '0;
    end

    // Gather lane flags into vectors, masked while locked out.
    always_comb begin
        n_result = '0;
        for (int i = 0; i < LIVE_LANES; i++) begin
            n_result.held_bits[i]         = i_flags[i].held;
            n_result.press_edge_bits[i]   = i_flags[i].press_edge;
            n_result.release_edge_bits[i] = i_flags[i].release_edge;
            n_result.long_hold_bits[i]    = i_flags[i].long_hold;
            n_result.repeat_bits[i]       = i_flags[i].repeat_pulse;
        end
        if (locked) begin
            n_result = '0;
        end
        n_result.locked_out = locked;
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_lock_count <= '0;
        end else begin
            if (i_accept) begin
                r_valid      <= 1'b1;
                r_lock_count <= n_lock_count;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Result word register.
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid = r_valid;
    assign o_result    = r_result;

    // A locked-out word carries no held, release edge or repeat bits.
    a_locked_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_result.locked_out) |->
        (r_result.held_bits == '0 && r_result.repeat_bits == '0
         && r_result.release_edge_bits == '0))
        else $error("locked-out word carries action bits");

    // A lockout request with a nonzero length locks the word it arrives with.
    a_request_locks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_lockout_request && i_lockout_length != '0) |=>
        (r_valid && r_result.locked_out))
        else $error("lockout request did not lock its word");

    // Press and release edges of one action never coincide.
    a_edges_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> ((r_result.press_edge_bits & r_result.release_edge_bits) == '0))
        else $error("press and release edge together");

    // A press edge or a long hold implies the action is held.
    a_edge_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (((r_result.press_edge_bits | r_result.long_hold_bits)
                      & ~r_result.held_bits) == '0))
        else $error("edge or long hold without held");

    // A word is taken only when the output register can make room.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_out_ready) |-> !i_accept)
        else $error("pending result overwritten");

endmodule

[tb/sv/key_hold_repeat_tracker_test.sv]
// Self-checking test of key_hold_repeat_tracker: random and directed input words per frame,
// a bit-accurate tracker model, and random stalls on both sides of the block.
// Depends on khrt_pkg, khrt_channels and the key_hold_repeat_tracker RTL.
module key_hold_repeat_tracker_test;
    timeunit 1ns;
    timeprecision 1ps;

    import khrt_pkg::*;

    localparam int unsigned COUNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam int STALL_PCT = 36;
    localparam int WATCHDOG_LIMIT = 2000;

    // One input word as queued for the driver.
    typedef struct packed {
        logic [VEC_W-1:0] pressed;
        logic             lock_req;
    } t_frame;

    logic i_clk;
    logic i_rst_n;

    khrt_in_if  in_ch();
    khrt_out_if out_ch();
    khrt_cfg_if cfg_ch();

    key_hold_repeat_tracker dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_ch  (in_ch),
        .o_out_ch (out_ch),
        .i_cfg_ch (cfg_ch)
    );

    // Frames waiting to be driven and result words waiting to be seen.
    t_frame  pending_frames[$];
    t_result expected_results[$];
    t_frame  drive_frame;
    t_result want_word;
    int      n_fail;
    int      idle_cycles;
    logic    steady;

    // Shadow of the configuration registers.
    logic [CFG_W-1:0]  set_thr;
    logic [CFG_W-1:0]  set_wait;
    logic [CFG_W-1:0]  set_ivl;
    logic [LOCK_W-1:0] set_lock_len;

    // Shadow of the per-lane and lockout state.
    logic [COUNT_WIDTH-1:0] lane_hold [NUM_ACTIONS];
    logic [PHASE_W-1:0]     lane_phase [NUM_ACTIONS];
    logic [LOCK_W-1:0]      lock_left;
    logic                   lock_on;

    // Clock generation.
    initial begin
        i_clk = 1'b0;
    end
    always #5 i_clk = ~i_clk;

    // Advances the tracker state by one frame and returns the result word it produces.
    function automatic t_result track_frame(input logic [VEC_W-1:0] pressed,
                                            input logic lock_req);
        int unsigned thr;
        int unsigned wt;
        int unsigned ivl;
        int unsigned old_cnt;
        int unsigned new_cnt;
        int unsigned nx;
        logic        was;
        logic        pulse;
        t_result     r;
        thr = (set_thr == '0) ? 1 : set_thr;
        wt  = (set_wait == '0) ? 1 : set_wait;
        ivl = (set_ivl == '0) ? 1 : set_ivl;
        r   = '0;

        // A request reloads the lockout counter before the lanes update.
        if (lock_req) begin
            lock_left = set_lock_len;
            lock_on   = 1'b1;
        end

        for (int i = 0; i < NUM_ACTIONS; i++) begin
            old_cnt = lane_hold[i];
            was     = (old_cnt != 0);
            if (i < VEC_W && pressed[i]) begin
                new_cnt = (old_cnt < COUNT_MAX) ? old_cnt + 1 : old_cnt;
            end else begin
                new_cnt = 0;
            end
            lane_hold[i] = new_cnt[COUNT_WIDTH-1:0];

            // The repeat phase restarts when the count first reaches the wait.
            pulse = 1'b0;
            if (new_cnt >= wt) begin
                if (old_cnt < wt) begin
                    lane_phase[i] = '0;
                end else begin
                    nx = lane_phase[i] + 1;
                    lane_phase[i] = (nx >= ivl) ? '0 : nx[PHASE_W-1:0];
                end
                if (lane_phase[i] == '0) pulse = 1'b1;
            end else begin
                lane_phase[i] = '0;
            end
            if (new_cnt == 1) pulse = 1'b1;

            if (i < VEC_W) begin
                r.held_bits[i]         = (new_cnt != 0);
                r.press_edge_bits[i]   = (new_cnt != 0) && !was;
                r.release_edge_bits[i] = (new_cnt == 0) && was;
                r.long_hold_bits[i]    = (new_cnt >= thr);
                r.repeat_bits[i]       = pulse;
            end
        end

        // The lockout counter counts down while above zero and masks the vectors.
        if (lock_left != '0) begin
            lock_on   = 1'b1;
            lock_left = lock_left - 1'b1;
        end else begin
            lock_on = 1'b0;
        end
        if (lock_on) r = '0;
        r.locked_out = lock_on;
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            n_fail++;
        end
    endtask

    // Input driver: predicts each accepted word and presents the next one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                expected_results.push_back(track_frame(in_ch.pressed_bits,
                                                       in_ch.lockout_request));
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (pending_frames.size() != 0 &&
                    (steady || $urandom_range(99) >= STALL_PCT)) begin
                    drive_frame = pending_frames.pop_front();
                    in_ch.valid           <= 1'b1;
                    in_ch.pressed_bits    <= drive_frame.pressed;
                    in_ch.lockout_request <= drive_frame.lock_req;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compares each accepted word with the oldest prediction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_results.size() == 0) begin
                    $error("result word arrived with no prediction pending");
                    n_fail++;
                end else begin
                    want_word = expected_results.pop_front();
                    check_field("held_bits", want_word.held_bits, out_ch.held_bits);
                    check_field("press_edge_bits", want_word.press_edge_bits,
                                out_ch.press_edge_bits);
                    check_field("release_edge_bits", want_word.release_edge_bits,
                                out_ch.release_edge_bits);
                    check_field("long_hold_bits", want_word.long_hold_bits,
                                out_ch.long_hold_bits);
                    check_field("repeat_bits", want_word.repeat_bits, out_ch.repeat_bits);
                    check_field("locked_out", want_word.locked_out, out_ch.locked_out);
                end
            end
            out_ch.ready <= steady || ($urandom_range(99) >= STALL_PCT);
        end
    end

    // Watchdog on cycles without any handshake.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("key_hold_repeat_tracker verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Writes one register and mirrors it in the shadow copy.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        case (idx)
            REG_HOLD_THRESHOLD:  set_thr      = value;
            REG_REPEAT_WAIT:     set_wait     = value;
            REG_REPEAT_INTERVAL: set_ivl      = value;
            REG_LOCKOUT_LENGTH:  set_lock_len = value[LOCK_W-1:0];
            default: ;
        endcase
    endtask

    task automatic write_all(input logic [CFG_W-1:0] thr, input logic [CFG_W-1:0] wt,
                             input logic [CFG_W-1:0] ivl, input logic [CFG_W-1:0] len);
        write_reg(REG_HOLD_THRESHOLD, thr);
        write_reg(REG_REPEAT_WAIT, wt);
        write_reg(REG_REPEAT_INTERVAL, ivl);
        write_reg(REG_LOCKOUT_LENGTH, len);
    endtask

    // Waits until every queued word has been taken and every result has come back.
    task automatic drain_frames();
        while (pending_frames.size() != 0 || in_ch.valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic push_frame(input logic [VEC_W-1:0] pressed, input logic lock_req);
        pending_frames.push_back('{pressed: pressed, lock_req: lock_req});
    endtask

    // Mostly held-key sequences where each lane toggles rarely, with some noise words.
    task automatic queue_key_sequences(input int count, input int flip_pct,
                                       input int lock_pct);
        logic [VEC_W-1:0] keys;
        keys = VEC_W'($urandom);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(99) < 15) begin
                push_frame(VEC_W'($urandom), $urandom_range(99) < lock_pct);
            end else begin
                for (int b = 0; b < VEC_W; b++)
                    if ($urandom_range(99) < flip_pct) keys[b] = ~keys[b];
                push_frame(keys, $urandom_range(99) < lock_pct);
            end
        end
    endtask

    initial begin
        n_fail = 0;
        idle_cycles = 0;
        steady = 1'b0;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.pressed_bits = '0;
        in_ch.lockout_request = 1'b0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        set_thr = 16'd30;
        set_wait = 16'd30;
        set_ivl = 16'd5;
        set_lock_len = 8'd10;
        for (int i = 0; i < NUM_ACTIONS; i++) begin
            lane_hold[i] = '0;
            lane_phase[i] = '0;
        end
        lock_left = '0;
        lock_on = 1'b0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings, long holds so that the default wait is reached.
        queue_key_sequences(40, 4, 3);
        drain_frames();

        // Short settings: edges, repeat cadence and a three-frame lockout.
        write_all(16'd2, 16'd3, 16'd2, 16'd3);
        push_frame('0, 1'b0);
        repeat (5) push_frame('1, 1'b0);
        push_frame(10'h155, 1'b0);
        push_frame(10'h2AA, 1'b0);
        push_frame('0, 1'b0);
        push_frame('1, 1'b1);
        repeat (4) push_frame('1, 1'b0);
        push_frame('0, 1'b0);
        push_frame(10'h001, 1'b0);
        push_frame(10'h200, 1'b0);
        queue_key_sequences(60, 10, 4);
        drain_frames();

        // All settings zero: threshold, wait and interval act as one, and a lockout request locks nothing.
        write_all(16'd0, 16'd0, 16'd0, 16'd0);
        repeat (3) push_frame('1, 1'b0);
        push_frame('0, 1'b1);
        push_frame('1, 1'b0);
        push_frame('0, 1'b0);
        queue_key_sequences(50, 15, 5);
        drain_frames();

        // Minimum settings and the longest lockout, upper data bits set.
        write_all(16'd1, 16'd1, 16'd1, 16'hFFFF);
        queue_key_sequences(40, 10, 0);
        push_frame(VEC_W'($urandom), 1'b1);
        queue_key_sequences(256, 10, 0);
        drain_frames();

        // Largest threshold and a wait near it, with no stalls on either side: lanes 0 and 9 stay held
        // but never reach the wait or the threshold.
        write_all(16'hFFFF, 16'd65530, 16'd7, 16'd1);
        steady = 1'b1;
        for (int n = 0; n < 60; n++)
            push_frame(VEC_W'($urandom) | 10'h201, $urandom_range(99) < 5);
        push_frame('0, 1'b0);
        drain_frames();
        steady = 1'b0;

        // Random small settings.
        write_all(CFG_W'($urandom_range(1, 12)), CFG_W'($urandom_range(1, 10)),
                  CFG_W'($urandom_range(1, 6)), CFG_W'($urandom_range(0, 6)));
        queue_key_sequences(40, 12, 4);
        drain_frames();

        repeat (5) @(posedge i_clk);
        if (n_fail == 0) begin
            $display("key_hold_repeat_tracker verification clean");
        end else begin
            $display("key_hold_repeat_tracker verification failed");
        end
        $finish;
    end

endmodule
